// ----- rtl/increasing_triple_counter_assert.svh -----
// Assertion macros for the increasing triple counter.
// Included by the RTL modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef INCREASING_TRIPLE_COUNTER_ASSERT_SVH
`define INCREASING_TRIPLE_COUNTER_ASSERT_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge out of reset.
`define ITC_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Checks that a consequence holds in the same cycle as its cause.
`define ITC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a consequence holds in the cycle after its cause.
`define ITC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ITC_ASSERT(lbl, expr, msg)
`define ITC_ASSERT_IMPL(lbl, ante, cons, msg)
`define ITC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/itc_pkg.sv -----
// Shared sizes and the token type for the increasing triple counter.
// Used by itc_cell, itc_accum and increasing_triple_counter; depends on nothing.
package itc_pkg;

	// Data set bound and element width.
	localparam int MAX_ITEMS  = 1024;
	localparam int VALUE_BITS = 17;

	// Counter, index and product widths derived from the bound; fixed count and sum widths.
	localparam int CNT_W   = $clog2(MAX_ITEMS + 1);
	localparam int IDX_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int PROD_W  = 2 * CNT_W;
	localparam int COUNT_W = 31;
	localparam int SUM_W   = COUNT_W + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	// One b value travelling down the chain with its running counts.
	typedef struct packed {
		logic                  valid;
		logic [CNT_W-1:0]      remaining;
		logic [VALUE_BITS-1:0] b;
		logic [CNT_W-1:0]      below;
		logic [CNT_W-1:0]      above;
	} token_t;

endpackage

// ----- rtl/increasing_triple_counter.sv -----
// Top level of the increasing triple counter: control, b value memory and the cell chain.
// Depends on itc_pkg, itc_cell, itc_accum and increasing_triple_counter_assert.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  item    | in        | item_valid / item_ready    | a_value, b_value, c_value, last
//  result  | out       | result_valid / result_ready| triple_count
//
// Loading takes one request per cycle; each stored a and c enters the head of the chain.
// After a request with last, the block drains (n stored triples):
// b values leave the memory one per cycle and each travels the whole chain of MAX_ITEMS cells.
// item_ready is low during the drain; reset clears control state only, no memory sweep.
// A stalled result holds while new requests load; a finished drain waits for the result slot.
module increasing_triple_counter (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_ready,
	input  logic [itc_pkg::VALUE_BITS-1:0] a_value,
	input  logic [itc_pkg::VALUE_BITS-1:0] b_value,
	input  logic [itc_pkg::VALUE_BITS-1:0] c_value,
	input  logic                           last,
	output logic                           result_valid,
	input  logic                           result_ready,
	output logic [itc_pkg::COUNT_W-1:0]    triple_count
);
	import itc_pkg::*;

	`include "increasing_triple_counter_assert.svh"

	typedef enum logic {ST_LOAD, ST_DRAIN} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    item_cnt_q;
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    issue_q;
	logic                result_valid_q;
	logic [COUNT_W-1:0]  triple_count_q;

	logic                  item_acc;
	logic                  has_room;
	logic                  store_en;
	logic                  rd_en;
	logic                  rd_valid_s1;
	logic [VALUE_BITS-1:0] rd_data_s1;
	logic [VALUE_BITS-1:0] b_mem [MAX_ITEMS];
	logic                  drain_done;
	logic                  slot_free;

	logic [VALUE_BITS-1:0] a_w   [MAX_ITEMS+1];
	logic [VALUE_BITS-1:0] c_w   [MAX_ITEMS+1];
	token_t                tok_w [MAX_ITEMS+1];

	logic [COUNT_W-1:0]    acc_total;
	logic [CNT_W-1:0]      acc_added;

	// Request handshake and storage decision.
	assign item_ready = (state_q == ST_LOAD);
	assign item_acc   = item_valid && item_ready;
	assign has_room   = (item_cnt_q < CNT_W'(MAX_ITEMS));
	assign store_en   = item_acc && has_room;
	assign rd_en      = (state_q == ST_DRAIN) && (issue_q != n_q);
	assign slot_free  = !result_valid_q || result_ready;
	assign drain_done = (state_q == ST_DRAIN) && (acc_added == n_q);

	// Control state and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			item_cnt_q     <= '0;
			n_q            <= '0;
			issue_q        <= '0;
			result_valid_q <= 1'b0;
			triple_count_q <= '0;
		end else begin
			// A finished drain fills the result slot; otherwise an accepted result empties it.
			if (drain_done && slot_free) begin
				result_valid_q <= 1'b1;
				triple_count_q <= acc_total;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					if (item_acc) begin
						if (last) begin
							n_q        <= has_room ? (item_cnt_q + CNT_W'(1)) : item_cnt_q;
							item_cnt_q <= '0;
							issue_q    <= '0;
							state_q    <= ST_DRAIN;
						end else if (has_room) begin
							item_cnt_q <= item_cnt_q + CNT_W'(1);
						end
					end
				end
				ST_DRAIN: begin
					if (rd_en) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (drain_done && slot_free) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Memory of b values, written while loading and read in order while draining.
	always_ff @(posedge clk) begin
		if (store_en) begin
			b_mem[item_cnt_q[IDX_W-1:0]] <= b_value;
		end
		rd_data_s1 <= b_mem[issue_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
		end
	end

	// Head of the chain: new elements while loading, fresh tokens while draining.
	assign a_w[0] = a_value;
	assign c_w[0] = c_value;

	always_comb begin
		tok_w[0].valid     = rd_valid_s1;
		tok_w[0].remaining = n_q;
		tok_w[0].b         = rd_data_s1;
		tok_w[0].below     = '0;
		tok_w[0].above     = '0;
	end

	// Row of comparison cells.
	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		itc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (store_en),
			.a_in     (a_w[i]),
			.c_in     (c_w[i]),
			.a_out    (a_w[i+1]),
			.c_out    (c_w[i+1]),
			.tok_in   (tok_w[i]),
			.tok_out  (tok_w[i+1])
		);
	end

	// Products and saturating sum at the tail.
	itc_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (item_acc && last),
		.tok    (tok_w[MAX_ITEMS]),
		.total  (acc_total),
		.added  (acc_added)
	);

	assign result_valid = result_valid_q;
	assign triple_count = triple_count_q;

	// The fill count advances by one for every stored element that does not end the set.
	`ITC_ASSERT_NEXT(a_cnt_step, store_en && !last, item_cnt_q == $past(item_cnt_q) + CNT_W'(1), "item count did not advance")
	// Tokens are never issued beyond the stored set.
	`ITC_ASSERT(a_issue_bound, issue_q <= n_q, "issue index past stored count")
	// The tail never takes in more products than tokens issued.
	`ITC_ASSERT_IMPL(a_added_bound, state_q == ST_DRAIN, acc_added <= issue_q, "more products than tokens")
	// A new result appears only when every token has been summed.
	`ITC_ASSERT_IMPL(a_result_done, $rose(result_valid_q), $past(acc_added == n_q), "result before drain end")

endmodule

// ----- rtl/itc_cell.sv -----
// One cell of the comparison chain: holds one stored (a, c) pair and updates passing tokens.
// Depends on itc_pkg for widths and token_t.
module itc_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  logic [itc_pkg::VALUE_BITS-1:0] a_in,
	input  logic [itc_pkg::VALUE_BITS-1:0] c_in,
	output logic [itc_pkg::VALUE_BITS-1:0] a_out,
	output logic [itc_pkg::VALUE_BITS-1:0] c_out,
	input  itc_pkg::token_t               tok_in,
	output itc_pkg::token_t               tok_out
);
	import itc_pkg::*;

	logic [VALUE_BITS-1:0] a_q;
	logic [VALUE_BITS-1:0] c_q;
	logic                  valid_q;
	token_t                pay_q;
	logic                  hit;
	logic                  a_below;
	logic                  c_above;

	// The stored pair shifts toward the tail as new elements are loaded.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			a_q <= a_in;
			c_q <= c_in;
		end
	end

	// A token counts this cell only while it still has stored entries left to visit.
	assign hit     = tok_in.valid && (tok_in.remaining != '0);
	assign a_below = hit && (a_q < tok_in.b);
	assign c_above = hit && (c_q > tok_in.b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		pay_q.valid     <= 1'b0;
		pay_q.b         <= tok_in.b;
		pay_q.remaining <= hit ? (tok_in.remaining - CNT_W'(1)) : tok_in.remaining;
		pay_q.below     <= tok_in.below + CNT_W'(a_below);
		pay_q.above     <= tok_in.above + CNT_W'(c_above);
	end

	// Reassemble the registered token with its reset valid bit.
	always_comb begin
		tok_out       = pay_q;
		tok_out.valid = valid_q;
	end

	assign a_out = a_q;
	assign c_out = c_q;

endmodule

// ----- rtl/itc_accum.sv -----
// Tail of the chain: multiplies each token's counts and sums the products with saturation.
// Depends on itc_pkg for widths and token_t.
module itc_accum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       clear,
	input  itc_pkg::token_t            tok,
	output logic [itc_pkg::COUNT_W-1:0] total,
	output logic [itc_pkg::CNT_W-1:0]   added
);
	import itc_pkg::*;

	logic              valid_s1;
	logic [PROD_W-1:0] prod_s1;
	logic [COUNT_W-1:0] acc_q;
	logic [CNT_W-1:0]   added_q;
	logic [SUM_W-1:0]   sum;

	// Product of the counts below and above, registered before the add.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= tok.valid && !clear;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(tok.below) * PROD_W'(tok.above);
	end

	// Saturating running sum and the number of products taken in.
	assign sum = {1'b0, acc_q} + SUM_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			added_q <= '0;
		end else if (clear) begin
			acc_q   <= '0;
			added_q <= '0;
		end else if (valid_s1) begin
			acc_q   <= (sum > SUM_W'(COUNT_MAX)) ? COUNT_MAX : sum[COUNT_W-1:0];
			added_q <= added_q + CNT_W'(1);
		end
	end

	assign total = acc_q;
	assign added = added_q;

endmodule

// ----- sim/triple_count_checker.sv -----
`timescale 1ns / 100ps
// Checker for the increasing triple counter: watches both channels and predicts each count.
// Depends on itc_pkg for the element width, the store bound and the count width.
module triple_count_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	input  logic                           item_ready,
	input  logic [itc_pkg::VALUE_BITS-1:0] a_value,
	input  logic [itc_pkg::VALUE_BITS-1:0] b_value,
	input  logic [itc_pkg::VALUE_BITS-1:0] c_value,
	input  logic                           last,
	input  logic                           result_valid,
	input  logic                           result_ready,
	input  logic [itc_pkg::COUNT_W-1:0]    triple_count,
	output int                             mismatches,
	output int                             pending_counts,
	output int                             counts_checked
);
	import itc_pkg::*;

	// Elements of the data set being loaded; requests past the store bound are dropped.
	logic [VALUE_BITS-1:0] a_loaded[$];
	logic [VALUE_BITS-1:0] b_loaded[$];
	logic [VALUE_BITS-1:0] c_loaded[$];

	// Counts predicted for finished data sets, oldest first.
	logic [COUNT_W-1:0] counts_due[$];

	int mismatch_total;
	int checked_total;

	// Sum over every b of (a values below it) times (c values above it), saturated.
	function automatic logic [COUNT_W-1:0] count_increasing_triples();
		longint unsigned total;
		longint unsigned below;
		longint unsigned above;
		total = 0;
		foreach (b_loaded[j]) begin
			below = 0;
			above = 0;
			foreach (a_loaded[i]) begin
				if (a_loaded[i] < b_loaded[j])
					below++;
				if (c_loaded[i] > b_loaded[j])
					above++;
			end
			total += below * above;
		end
		if (total > COUNT_MAX)
			return COUNT_MAX;
		return total[COUNT_W-1:0];
	endfunction

	// Compare finished counts first, then record the request of the same edge.
	always @(posedge clk or negedge arst_n) begin
		logic [COUNT_W-1:0] want;
		if (!arst_n) begin
			a_loaded.delete();
			b_loaded.delete();
			c_loaded.delete();
			counts_due.delete();
			mismatch_total = 0;
			checked_total = 0;
			mismatches <= 0;
			pending_counts <= 0;
			counts_checked <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (counts_due.size() == 0) begin
					$error("triple_count %0d arrived with no count outstanding", triple_count);
					mismatch_total++;
				end else begin
					want = counts_due.pop_front();
					if (triple_count !== want) begin
						$error("triple_count mismatch: expected %0d, actual %0d",
							want, triple_count);
						mismatch_total++;
					end
					checked_total++;
				end
			end
			if (item_valid && item_ready) begin
				if (a_loaded.size() < MAX_ITEMS) begin
					a_loaded.push_back(a_value);
					b_loaded.push_back(b_value);
					c_loaded.push_back(c_value);
				end
				if (last) begin
					counts_due.push_back(count_increasing_triples());
					a_loaded.delete();
					b_loaded.delete();
					c_loaded.delete();
				end
			end
			mismatches <= mismatch_total;
			pending_counts <= counts_due.size();
			counts_checked <= checked_total;
		end
	end

endmodule

// ----- sim/increasing_triple_counter_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the increasing triple counter: clock, reset, requests and verdict.
// Depends on itc_pkg, increasing_triple_counter and triple_count_checker.
module increasing_triple_counter_tb;
	import itc_pkg::*;

	localparam logic [VALUE_BITS-1:0] VALUE_TOP = '1;
	localparam int TARGET_REQUESTS = 1450;
	localparam int HOLD_OFF        = 3000;
	localparam int DRAIN_CYCLES    = 2 * MAX_ITEMS + 16;
	localparam int STALL_LIMIT     = 4 * (DRAIN_CYCLES + HOLD_OFF + 100);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  item_valid = 1'b0;
	logic                  item_ready;
	logic [VALUE_BITS-1:0] a_value = '0;
	logic [VALUE_BITS-1:0] b_value = '0;
	logic [VALUE_BITS-1:0] c_value = '0;
	logic                  last = 1'b0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	logic [COUNT_W-1:0]    triple_count;

	int  mismatches;
	int  pending_counts;
	int  counts_checked;
	int  requests_sent = 0;
	int  sets_sent = 0;
	bit  steady_set = 1'b0;

	increasing_triple_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.a_value      (a_value),
		.b_value      (b_value),
		.c_value      (c_value),
		.last         (last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.triple_count (triple_count)
	);

	triple_count_checker count_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.a_value        (a_value),
		.b_value        (b_value),
		.c_value        (c_value),
		.last           (last),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.triple_count   (triple_count),
		.mismatches     (mismatches),
		.pending_counts (pending_counts),
		.counts_checked (counts_checked)
	);

	// Free-running clock, 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Idle length: mostly none, often short, now and then a long pause.
	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 60);
	endfunction

	// Offer one request, after an optional idle gap, and wait until it is taken.
	task automatic send_request(input logic [VALUE_BITS-1:0] a, input logic [VALUE_BITS-1:0] b,
		input logic [VALUE_BITS-1:0] c, input logic end_of_set);
		int gap;
		gap = steady_set ? 0 : gap_length();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		a_value <= a;
		b_value <= b;
		c_value <= c;
		last <= end_of_set;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		requests_sent++;
		if (end_of_set)
			sets_sent++;
	endtask

	// Stop offering requests until every predicted count has come back.
	task automatic wait_for_counts();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending_counts != 0)
			@(posedge clk);
	endtask

	// One data set of n requests with random content in one of several value shapes.
	task automatic send_random_set(input int n);
		int shape;
		logic [VALUE_BITS-1:0] a, b, c;
		shape = $urandom_range(0, 3);
		steady_set = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < n; i++) begin
			case (shape)
				0: begin
					a = VALUE_BITS'($urandom_range(0, VALUE_TOP));
					b = VALUE_BITS'($urandom_range(0, VALUE_TOP));
					c = VALUE_BITS'($urandom_range(0, VALUE_TOP));
				end
				1: begin
					// Tiny range, so ties and nonzero counts are common.
					a = VALUE_BITS'($urandom_range(0, 7));
					b = VALUE_BITS'($urandom_range(0, 7));
					c = VALUE_BITS'($urandom_range(0, 7));
				end
				2: begin
					// Mostly increasing bands, giving large counts.
					a = VALUE_BITS'($urandom_range(0, 40000));
					b = VALUE_BITS'($urandom_range(30000, 90000));
					c = VALUE_BITS'($urandom_range(80000, VALUE_TOP));
				end
				default: begin
					// Values pinned at the extremes or next to them.
					a = ($urandom_range(0, 1) == 0) ? VALUE_BITS'($urandom_range(0, 1))
						: VALUE_TOP;
					b = ($urandom_range(0, 1) != 0)
						? VALUE_TOP - VALUE_BITS'($urandom_range(0, 1))
						: VALUE_BITS'($urandom_range(0, 2));
					c = ($urandom_range(0, 1) == 0) ? VALUE_BITS'($urandom_range(0, 1))
						: VALUE_TOP;
				end
			endcase
			send_request(a, b, c, i == n - 1);
		end
	endtask

	// Result side: random stalls, long open stretches, and one long hold-off.
	initial begin
		bit held_off;
		int stall;
		int run;
		held_off = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!held_off && counts_checked >= 20) begin
				held_off = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_OFF) @(posedge clk);
			end else begin
				stall = gap_length();
				if (stall > 0) begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(1, 16);
				result_ready <= 1'b1;
				repeat (run) @(posedge clk);
			end
		end
	end

	// Watchdog: end the run when nothing moves on either channel for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	// Reset, directed sets, random sets, then drain and verdict.
	initial begin
		int size_pick;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Single-request sets: equal values, the smallest rise, the top of the range.
		send_request('0, '0, '0, 1'b1);
		send_request(VALUE_BITS'(0), VALUE_BITS'(1), VALUE_BITS'(2), 1'b1);
		send_request('0, VALUE_TOP - VALUE_BITS'(1), VALUE_TOP, 1'b1);
		send_request(VALUE_TOP, VALUE_TOP, VALUE_TOP, 1'b1);

		// Alternating bit patterns mixed with the extremes.
		send_request(17'h15555, 17'h0AAAA, VALUE_TOP, 1'b0);
		send_request(17'h0AAAA, 17'h15555, '0, 1'b0);
		send_request(VALUE_BITS'(1), VALUE_BITS'(1), VALUE_BITS'(1), 1'b0);
		send_request(VALUE_BITS'(0), VALUE_BITS'(2), VALUE_BITS'(3), 1'b1);

		// Ties: a equal to b or c equal to b never counts.
		send_request(VALUE_BITS'(5), VALUE_BITS'(5), VALUE_BITS'(5), 1'b0);
		send_request(VALUE_BITS'(4), VALUE_BITS'(5), VALUE_BITS'(6), 1'b0);
		send_request(VALUE_BITS'(5), VALUE_BITS'(6), VALUE_BITS'(5), 1'b1);

		// Opposite extremes, where no triple rises.
		send_request(VALUE_TOP, '0, VALUE_TOP, 1'b0);
		send_request('0, VALUE_TOP, '0, 1'b1);

		// Random data sets, with a pause, a full store and an overflowing request on the way.
		while (requests_sent < TARGET_REQUESTS) begin
			if (sets_sent == 30) begin
				// Largest count: a full store of rising triples, then one request with last
				// that arrives with the store full and is not stored.
				steady_set = ($urandom_range(0, 1) == 0);
				for (int i = 0; i < MAX_ITEMS; i++)
					send_request(VALUE_BITS'(0), VALUE_BITS'(1), VALUE_BITS'(2), 1'b0);
				send_request(VALUE_BITS'($urandom_range(0, VALUE_TOP)),
					VALUE_BITS'($urandom_range(0, VALUE_TOP)),
					VALUE_BITS'($urandom_range(0, VALUE_TOP)), 1'b1);
			end else begin
				if (sets_sent == 15)
					wait_for_counts();
				size_pick = $urandom_range(0, 99);
				if (size_pick < 70)
					send_random_set($urandom_range(1, 8));
				else if (size_pick < 95)
					send_random_set($urandom_range(9, 40));
				else
					send_random_set($urandom_range(41, 120));
			end
		end

		wait_for_counts();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Loaded %0d requests in %0d data sets, one of them past the store bound.",
			requests_sent, sets_sent);
		$display("Checked %0d triple counts with %0d mismatches.", counts_checked, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ----- increasing_triple_counter.f -----
+incdir+rtl
rtl/itc_pkg.sv
rtl/itc_cell.sv
rtl/itc_accum.sv
rtl/increasing_triple_counter.sv
sim/triple_count_checker.sv
sim/increasing_triple_counter_tb.sv
